[rtl/lspj_pkg.sv]
// Package with the shared types, codes and helper function of the line sensor block.
package lspj_pkg;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_START,
        ST_DIV,
        ST_DONE
    } state_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_ACTIVE_LOW = 2'd0;
    localparam logic [1:0] REG_JUNC_THR   = 2'd1;
    localparam logic [1:0] REG_FIN_THR    = 2'd2;

    // Junction class codes.
    localparam logic [2:0] JK_NONE    = 3'd0;
    localparam logic [2:0] JK_DEAD    = 3'd1;
    localparam logic [2:0] JK_LEFT90  = 3'd2;
    localparam logic [2:0] JK_RIGHT90 = 3'd3;
    localparam logic [2:0] JK_T_LEFT  = 3'd4;
    localparam logic [2:0] JK_T_RIGHT = 3'd5;
    localparam logic [2:0] JK_T_BOTH  = 3'd6;
    localparam logic [2:0] JK_CROSS   = 3'd7;

    // Divider widths: |sum| * 256 needs 13 bits, the sensor count 4 bits.
    localparam int DIVIDEND_W = 13;
    localparam int DIVISOR_W  = 4;

    // Status of the iterative divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Weight of sensor idx: -7, -5, ... +7, that is 2 * idx - 7.
    function automatic logic signed [4:0] sensor_weight(input logic [2:0] idx);
        logic signed [4:0] w;
        w = $signed({1'b0, idx, 1'b0}) - 5'sd7;
        return w;
    endfunction

endpackage

[rtl/lspj_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module lspj_div
    import lspj_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output div_status_t           status
);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [3:0]            step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    rem_shift;
    logic                  fits;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        rem_shift = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = 4'(DIVIDEND_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            if (step_reg == 4'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 4'd1;
            end
        end
    end

    // Control flags take reset; the datapath does not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        step_reg <= step_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[rtl/lspj_class.sv]
// Path bit and junction class decode for one sensor snapshot.
module lspj_class
    import lspj_pkg::*;
(
    input  logic [7:0] bits,
    input  logic [3:0] count,
    input  logic [3:0] junction_threshold,
    output logic       path_left,
    output logic       path_straight,
    output logic       path_right,
    output logic [2:0] junction_kind
);

    logic       junction;
    logic [1:0] n_paths;

    // Branch bits: outer pairs and center pair only count at a junction.
    always_comb begin
        junction = count >= junction_threshold;
        if (junction) begin
            path_left     = bits[6] | bits[7];
            path_right    = bits[0] | bits[1];
            path_straight = bits[3] | bits[4];
        end else begin
            path_left     = 1'b0;
            path_right    = 1'b0;
            path_straight = count != 4'd0;
        end
        n_paths = {1'b0, path_left} + {1'b0, path_straight} + {1'b0, path_right};
    end

    // Classify by how many branches are present and which.
    always_comb begin
        case (n_paths)
            2'd0: junction_kind = JK_DEAD;
            2'd1: begin
                if (path_left) begin
                    junction_kind = JK_LEFT90;
                end else if (path_right) begin
                    junction_kind = JK_RIGHT90;
                end else begin
                    junction_kind = JK_NONE;
                end
            end
            2'd2: begin
                if (path_left && path_straight) begin
                    junction_kind = JK_T_LEFT;
                end else if (path_right && path_straight) begin
                    junction_kind = JK_T_RIGHT;
                end else begin
                    junction_kind = JK_T_BOTH;
                end
            end
            default: junction_kind = JK_CROSS;
        endcase
    end

endmodule

[rtl/line_sensor_position_and_junction_top.sv]
// Top level of the line sensor position and junction block.
//
// The input channel (s_valid, s_ready, s_sensor_bits) takes one 8-bit snapshot
// of the sensor array per transaction. The result channel (m_valid, m_ready and
// the m_ fields) returns one result transaction per snapshot, in order.
// The configuration port (cfg_wr_en, cfg_index, cfg_wdata) writes polarity and
// the junction and finish thresholds; write it only while the block is idle.
// A snapshot is scanned one sensor per cycle through a single adder, then the
// mean position is formed by a restoring divider that yields one quotient bit
// per cycle. A snapshot with no active sensors skips the divider. s_ready is
// high only while the sequencer is idle, so one snapshot is in work at a time:
// a new snapshot is taken only after the previous one has left the sequencer.
// The result sits in an output register, so a new snapshot may be accepted
// while the previous result waits; if the receiver still stalls when the next
// snapshot is finished, that snapshot waits in the sequencer until the output
// register is free. Reset clears the sequencer, the output valid, the held
// position (to zero) and the registers to their defaults: active high sensors,
// junction threshold 5, finish 6.
module line_sensor_position_and_junction_top
    import lspj_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_sensor_bits,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [11:0] m_position,
    output logic [3:0]         m_active_count,
    output logic               m_on_line,
    output logic               m_path_left,
    output logic               m_path_straight,
    output logic               m_path_right,
    output logic [2:0]         m_junction_kind,
    output logic               m_line_end,
    output logic               m_finish_seen
);

    state_t state_reg, state_next;

    logic              active_low_reg;
    logic [3:0]        junc_thr_reg;
    logic [3:0]        fin_thr_reg;
    logic [7:0]        bits_reg;
    logic [2:0]        idx_reg, idx_next;
    logic signed [5:0] sum_reg, sum_next;
    logic [3:0]        count_reg, count_next;
    logic [11:0]       held_position_reg;
    logic              m_valid_reg;
    logic              accept;
    logic              div_start;
    logic              load_out;
    logic              out_free;
    logic [4:0]        sum_abs;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVIDEND_W-1:0] quotient;
    div_status_t       div_status;
    logic              path_left;
    logic              path_straight;
    logic              path_right;
    logic [2:0]        junction_kind;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_low_reg <= 1'b0;
            junc_thr_reg   <= 4'd5;
            fin_thr_reg    <= 4'd6;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ACTIVE_LOW: active_low_reg <= cfg_wdata[0];
                REG_JUNC_THR:   junc_thr_reg   <= cfg_wdata;
                REG_FIN_THR:    fin_thr_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_SCAN;
            ST_SCAN:  if (idx_reg == 3'd7) state_next = ST_START;
            ST_START: state_next = (count_reg == 4'd0) ? ST_DONE : ST_DIV;
            ST_DIV:   if (div_status.done) state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready   = 1'b1;
            ST_START: div_start = count_reg != 4'd0;
            ST_DONE:  load_out  = out_free;
            default: ;
        endcase
    end

    // Scan step: add one sensor's weight and count it when it sees the line.
    always_comb begin
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept) begin
            idx_next   = '0;
            sum_next   = '0;
            count_next = '0;
        end else if (state_reg == ST_SCAN) begin
            idx_next = idx_reg + 3'd1;
            if (bits_reg[idx_reg]) begin
                sum_next   = sum_reg + 6'(sensor_weight(idx_reg));
                count_next = count_reg + 4'd1;
            end
        end
    end

    // Dividend is |sum| scaled by 256; the sign is restored afterwards.
    assign sum_abs  = sum_reg[5] ? 5'(-sum_reg) : sum_reg[4:0];
    assign dividend = {sum_abs, 8'd0};

    lspj_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    lspj_class u_class (
        .bits               (bits_reg),
        .count              (count_reg),
        .junction_threshold (junc_thr_reg),
        .path_left          (path_left),
        .path_straight      (path_straight),
        .path_right         (path_right),
        .junction_kind      (junction_kind)
    );

    // Sequencer, scan datapath and held position.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            held_position_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DIV && div_status.done) begin
                held_position_reg <= sum_reg[5] ? (12'd0 - quotient[11:0]) : quotient[11:0];
            end
        end
        if (accept) begin
            bits_reg <= active_low_reg ? ~s_sensor_bits : s_sensor_bits;
        end
        idx_reg   <= idx_next;
        sum_reg   <= sum_next;
        count_reg <= count_next;
    end

    // Output register: holds a result until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (load_out) begin
            m_position      <= $signed(held_position_reg);
            m_active_count  <= count_reg;
            m_on_line       <= count_reg != 4'd0;
            m_path_left     <= path_left;
            m_path_straight <= path_straight;
            m_path_right    <= path_right;
            m_junction_kind <= junction_kind;
            m_line_end      <= count_reg == 4'd0;
            m_finish_seen   <= count_reg >= fin_thr_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
